// ----- rtl/core/mct_pkg.sv -----
// Shared constants, codes and types of the monotone closure table.
`timescale 1ns / 1ps
package mct_pkg;

  // Default table size in deciders
  localparam int MAX_DECIDERS_DEF = 10;

  // Fixed field widths
  localparam int SUBSET_W = 10;
  localparam int DEC_W    = 4;
  localparam int N_W      = 5;
  localparam int IN_W     = 16;
  localparam int OUT_FIXED_W = 5;

  localparam logic [DEC_W-1:0] DECIDERS_RESET = 4'd10;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Table marks
  typedef logic [1:0] mark_t;
  localparam mark_t MARK_UNDET = 2'd0;
  localparam mark_t MARK_INCL  = 2'd1;
  localparam mark_t MARK_EXCL  = 2'd2;

  // Command codes produced by the front
  typedef logic [1:0] op_t;
  localparam op_t OP_READ = 2'd0;
  localparam op_t OP_INCL = 2'd1;
  localparam op_t OP_EXCL = 2'd2;
  localparam op_t OP_OOR  = 2'd3;

  typedef struct packed {
    op_t                 op;
    logic [SUBSET_W-1:0] subset;
  } cmd_t;

endpackage

// ----- rtl/core/mct_cmd_queue.sv -----
// Short command queue between the front and the back of the closure table.
`timescale 1ns / 1ps
module mct_cmd_queue import mct_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign head  = slot_r[rptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("command popped from an empty queue");

endmodule

// ----- rtl/core/mct_front.sv -----
// Front of the closure table: deciders register, item intake and classification.
`timescale 1ns / 1ps
module mct_front import mct_pkg::*; #(
  parameter int MAX_DECIDERS = MAX_DECIDERS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tuser,
  input  logic             cfg_we,
  input  logic [DEC_W-1:0] cfg_wdata,
  input  logic             clearing,
  input  logic             q_full,
  output logic             push,
  output cmd_t             push_cmd,
  output logic [N_W-1:0]   n_eff
);

  logic [DEC_W-1:0]    deciders_r;
  logic [SUBSET_W-1:0] subset;
  logic                present;
  logic                oor;

  // Hold the deciders register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deciders_r <= DECIDERS_RESET;
    end else if (cfg_we) begin
      deciders_r <= cfg_wdata;
    end
  end

  // Clamp the register to 1..MAX_DECIDERS
  always_comb begin
    if (deciders_r == '0) begin
      n_eff = N_W'(1);
    end else if (N_W'(deciders_r) > N_W'(MAX_DECIDERS)) begin
      n_eff = N_W'(MAX_DECIDERS);
    end else begin
      n_eff = N_W'(deciders_r);
    end
  end

  // Take items while the queue has room and no clearing pass runs
  assign in_tready = !q_full && !clearing;
  assign push      = in_tvalid && in_tready;

  assign subset  = in_tdata[SUBSET_W-1:0];
  assign present = in_tdata[SUBSET_W];
  assign oor     = ((subset >> n_eff) != '0);

  // Classify the item into a back-end command
  always_comb begin
    push_cmd.subset = subset;
    if (oor) begin
      push_cmd.op = OP_OOR;
    end else if (in_tuser) begin
      push_cmd.op = OP_READ;
    end else if (present) begin
      push_cmd.op = OP_INCL;
    end else begin
      push_cmd.op = OP_EXCL;
    end
  end

endmodule

// ----- rtl/core/mct_back.sv -----
// Back of the closure table: mark memory, walker, undetermined count, result register.
`timescale 1ns / 1ps
module mct_back import mct_pkg::*; #(
  parameter int MAX_DECIDERS = MAX_DECIDERS_DEF,
  parameter int OUT_W_CALC   = ((OUT_FIXED_W + MAX_DECIDERS + 1 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear_req,
  input  logic [N_W-1:0]        n_eff,
  input  logic                  q_empty,
  input  cmd_t                  q_head,
  output logic                  q_pop,
  output logic                  clearing,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W_CALC-1:0] out_tdata
);

  localparam int ADDR_W = MAX_DECIDERS;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CNT_W  = MAX_DECIDERS + 1;
  localparam int WIDE_W = (ADDR_W > SUBSET_W) ? ADDR_W : SUBSET_W;
  localparam int OUT_W  = OUT_W_CALC;

  // Back-end states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Walk modes
  localparam logic [1:0] W_SUPER = 2'd0;
  localparam logic [1:0] W_COMPL = 2'd1;
  localparam logic [1:0] W_SUB   = 2'd2;

  mark_t             mem [DEPTH];
  mark_t             rdata_r;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [ADDR_W-1:0] t_r, t_nxt;
  logic [ADDR_W-1:0] sub_r, sub_nxt;
  op_t               op_r, op_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              conflict_r, conflict_nxt;
  mark_t             mark_r, mark_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic [ADDR_W-1:0] s1_addr_r;
  mark_t             s1_mark_r;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic [CNT_W-1:0]  size;
  logic [ADDR_W-1:0] full;
  logic [WIDE_W-1:0] head_wide;
  logic [ADDR_W-1:0] head_addr;
  logic              match;
  mark_t             walk_mark;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  mark_t             wdata;
  logic              s1_fill;
  logic              out_free;

  assign size      = CNT_W'(1) << n_eff;
  assign full      = ADDR_W'(size - CNT_W'(1));
  assign head_wide = WIDE_W'(q_head.subset);
  assign head_addr = head_wide[ADDR_W-1:0];
  assign clearing  = (state_r == ST_CLEAR);
  assign out_free  = !out_valid_r || out_tready;

  // Entry test of the current walk
  always_comb begin
    case (mode_r)
      W_SUPER: match = ((t_r & sub_r) == sub_r);
      W_COMPL: match = ((t_r & sub_r) == '0);
      default: match = ((t_r & ~sub_r) == '0);
    endcase
    walk_mark = (mode_r == W_SUPER) ? MARK_INCL : MARK_EXCL;
  end

  // Memory ports: read at the head command or walk position, write from clearing or stage 1
  assign raddr   = (state_r == ST_IDLE) ? head_addr : t_r;
  assign s1_fill = s1_valid_r && (rdata_r == MARK_UNDET);
  assign we      = clearing || s1_fill;
  assign waddr   = clearing ? clr_addr_r : s1_addr_r;
  assign wdata   = clearing ? MARK_UNDET : s1_mark_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Sequence clearing, walks and result hand-off
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    t_nxt         = t_r;
    sub_nxt       = sub_r;
    op_nxt        = op_r;
    clr_addr_nxt  = clr_addr_r;
    count_nxt     = count_r;
    conflict_nxt  = conflict_r;
    mark_nxt      = mark_r;
    s1_valid_nxt  = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;

    // Stage 1: settle the entry read in the previous cycle
    if (s1_valid_r) begin
      if (rdata_r == MARK_UNDET) begin
        if (count_r != '0) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end else if (rdata_r != s1_mark_r) begin
        conflict_nxt = 1'b1;
      end
    end

    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          count_nxt = size;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          op_nxt       = q_head.op;
          sub_nxt      = head_addr;
          conflict_nxt = 1'b0;
          mark_nxt     = MARK_UNDET;
          t_nxt        = '0;
          case (q_head.op)
            OP_READ: state_nxt = ST_DRAIN;
            OP_INCL: begin
              mode_nxt  = W_SUPER;
              state_nxt = ST_WALK;
            end
            OP_EXCL: begin
              mode_nxt  = W_SUB;
              state_nxt = ST_WALK;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_WALK: begin
        s1_valid_nxt = match;
        t_nxt        = t_r + ADDR_W'(1);
        if (t_r == full) begin
          t_nxt = '0;
          if (mode_r == W_SUPER) begin
            mode_nxt = W_COMPL;
          end else begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (op_r == OP_READ) begin
          mark_nxt = rdata_r;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({(count_r == '0), count_r, (op_r == OP_OOR),
                                  conflict_r, mark_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase

    // Restart the clearing pass on a register write
    if (clear_req) begin
      state_nxt    = ST_CLEAR;
      clr_addr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      conflict_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      conflict_r  <= conflict_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    t_r        <= t_nxt;
    sub_r      <= sub_nxt;
    op_r       <= op_nxt;
    mark_r     <= mark_nxt;
    s1_addr_r  <= t_r;
    s1_mark_r  <= walk_mark;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |-> (count_r <= size))
    else $error("undetermined count above table size");

  a_stage1_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ((state_r == ST_WALK) || (state_r == ST_DRAIN)))
    else $error("table update outside a walk");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> ((state_r == ST_IDLE) && !s1_valid_r))
    else $error("command taken while a walk is still open");

endmodule

// ----- rtl/core/monotone_closure_table.sv -----
// Top level of the monotone closure table: front, command queue and back.
//
//   Channel  Direction  Ports                          Payload
//   in       slave      in_tvalid/in_tready/in_tdata   tuser kind; tdata subset, present
//   out      master     out_tvalid/out_tready/out_tdata tdata mark, conflict, range,
//                                                       count, determined
//   cfg      write      cfg_we/cfg_wdata               deciders_in_use
//
// A read goes through the drain and done states, an out-of-range item straight to
// done. An excluded decision walks 2^n entries, an included one 2 * 2^n, one entry
// per cycle through the single mark memory, plus the steps to take, settle and
// report it. After reset and after every register write a clearing pass over all
// 2^MAX_DECIDERS entries resets the memory; in_tready stays low until it ends. The
// two-entry queue keeps taking items while the back walks or a result waits.
`timescale 1ns / 1ps
module monotone_closure_table import mct_pkg::*; #(
  parameter int MAX_DECIDERS = MAX_DECIDERS_DEF,
  parameter int OUT_W_CALC   = ((OUT_FIXED_W + MAX_DECIDERS + 1 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [9:0] subset, [10] present
  input  logic [IN_W-1:0]       in_tdata,
  // [0] kind
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] entry_mark, [2] conflict, [3] out_of_range,
  // [MAX_DECIDERS+4:4] undetermined_left, [MAX_DECIDERS+5] determined
  output logic [OUT_W_CALC-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [DEC_W-1:0]      cfg_wdata
);

  logic           clearing;
  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  cmd_t           push_cmd;
  cmd_t           head;
  logic [N_W-1:0] n_eff;

  mct_front #(
    .MAX_DECIDERS (MAX_DECIDERS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .n_eff     (n_eff)
  );

  mct_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  mct_back #(
    .MAX_DECIDERS (MAX_DECIDERS),
    .OUT_W_CALC   (OUT_W_CALC)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear_req  (cfg_we),
    .n_eff      (n_eff),
    .q_empty    (q_empty),
    .q_head     (head),
    .q_pop      (pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- test/monotone_closure_table_tb.sv -----
// Self-checking testbench for the monotone closure table: directed rows, random phases.
`timescale 1ns / 1ps
module monotone_closure_table_tb;
  import mct_pkg::*;

  localparam int TB_DECIDERS = 10;
  localparam int TABLE_SIZE  = 1 << TB_DECIDERS;
  localparam int RES_W       = ((OUT_FIXED_W + TB_DECIDERS + 1 + 7) / 8) * 8;
  localparam int STALL_LIMIT = 20000;
  localparam int REPORT_MAX  = 10;

  // Item kinds carried on in_tuser
  localparam logic KIND_APPLY = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    mark_t       mark;
    logic        conflict;
    logic        oor;
    logic [10:0] left;
    logic        det;
  } closure_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_action_e;

  typedef struct {
    row_action_e     action;
    logic [3:0]      cfg_value;
    logic            kind;
    logic [9:0]      subset;
    logic            present;
    logic            typed;
    closure_result_t want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [RES_W-1:0] out_tdata;
  logic             cfg_we = 1'b0;
  logic [DEC_W-1:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Predictor state: one mark per subset plus the undetermined count
  mark_t closure_marks [TABLE_SIZE];
  int    undet_left;
  int    n_active;
  logic  walk_conflict;

  closure_result_t expected_closure [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int reads_seen = 0;
  int conflicts_seen = 0;
  int oor_seen = 0;
  int determined_seen = 0;

  monotone_closure_table #(.MAX_DECIDERS(TB_DECIDERS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Load a decider count into the predictor and clear its table
  function automatic void load_deciders(logic [3:0] value);
    n_active = (value == 4'd0) ? 1 : (int'(value) > TB_DECIDERS) ? TB_DECIDERS : int'(value);
    for (int i = 0; i < TABLE_SIZE; i++) closure_marks[i] = MARK_UNDET;
    undet_left = 1 << n_active;
  endfunction

  // Set one entry unless it already holds a mark; flag the opposite mark
  function automatic void mark_entry(int idx, mark_t m);
    if (closure_marks[idx] == MARK_UNDET) begin
      closure_marks[idx] = m;
      undet_left--;
    end else if (closure_marks[idx] != m) begin
      walk_conflict = 1'b1;
    end
  endfunction

  function automatic closure_result_t predict_closure(logic kind, logic [9:0] subset,
                                                      logic present);
    closure_result_t res;
    int size;
    size = 1 << n_active;
    res = '0;
    walk_conflict = 1'b0;
    if (int'(subset) >= size) begin
      res.oor = 1'b1;
    end else if (kind == KIND_READ) begin
      res.mark = closure_marks[subset];
    end else if (present) begin
      // Supersets go included, then subsets of the complement go excluded
      for (int t = 0; t < size; t++)
        if ((10'(t) & subset) == subset) mark_entry(t, MARK_INCL);
      for (int t = 0; t < size; t++)
        if ((10'(t) & subset) == 10'd0) mark_entry(t, MARK_EXCL);
    end else begin
      for (int t = 0; t < size; t++)
        if ((10'(t) & ~subset) == 10'd0) mark_entry(t, MARK_EXCL);
    end
    res.conflict = walk_conflict;
    res.left = 11'(undet_left);
    res.det = (undet_left == 0);
    return res;
  endfunction

  function automatic plan_row_t item_row(logic kind, logic [9:0] subset, logic present);
    plan_row_t r;
    r = '{action: ROW_ITEM, cfg_value: 4'd0, kind: kind, subset: subset, present: present,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic kind, logic [9:0] subset, logic present,
                                          mark_t mark, logic conflict, logic oor,
                                          logic [10:0] left);
    plan_row_t r;
    r = item_row(kind, subset, present);
    r.typed = 1'b1;
    r.want = '{mark: mark, conflict: conflict, oor: oor, left: left, det: (left == 11'd0)};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [3:0] value);
    plan_row_t r;
    r = item_row(KIND_APPLY, 10'd0, 1'b0);
    r.action = ROW_CFG;
    r.cfg_value = value;
    return r;
  endfunction

  // Present one item, hold it until accepted, then queue its expected result
  task automatic send_item(logic kind, logic [9:0] subset, logic present, logic typed,
                           closure_result_t want);
    closure_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {{(IN_W - 11){1'b0}}, present, subset};
    do @(posedge clk); while (!in_tready);
    res = predict_closure(kind, subset, present);
    expected_closure.push_back(typed ? want : res);
    items_sent++;
  endtask

  // Hold the sender until every queued result has come back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_closure.size() != 0);
  endtask

  task automatic write_deciders(logic [3:0] value);
    wait_for_results();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    load_deciders(value);
  endtask

  // Receiver: stall at random
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    closure_result_t got;
    closure_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{mark: out_tdata[1:0], conflict: out_tdata[2], oor: out_tdata[3],
              left: out_tdata[TB_DECIDERS+4:4], det: out_tdata[TB_DECIDERS+5]};
      if (expected_closure.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: mark %0d conflict %0b oor %0b left %0d det %0b",
                   got.mark, got.conflict, got.oor, got.left, got.det);
      end else begin
        want = expected_closure.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch: expected mark %0d conflict %0b oor %0b left %0d det %0b,",
                     want.mark, want.conflict, want.oor, want.left, want.det,
                     " got mark %0d conflict %0b oor %0b left %0d det %0b",
                     got.mark, got.conflict, got.oor, got.left, got.det);
        end
      end
      if (got.oor) oor_seen++;
      if (got.conflict) conflicts_seen++;
      if (got.det) determined_seen++;
    end
    if (rst_n && in_tvalid && in_tready && in_tuser == KIND_READ) reads_seen++;
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("monotone_closure_table_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan [$];
    logic [3:0] phase_deciders [8];
    int phase_items [8];
    int size;
    logic kind;
    logic [9:0] subset;
    phase_deciders = '{4'd2, 4'd4, 4'd1, 4'd5, 4'd10, 4'd3, 4'd6, 4'd15};
    phase_items = '{40, 45, 20, 40, 20, 40, 45, 15};

    // Reset state: ten deciders, everything undetermined
    plan.push_back(typed_row(KIND_READ, 10'd0, 1'b0, MARK_UNDET, 1'b0, 1'b0, 11'd1024));
    plan.push_back(typed_row(KIND_READ, 10'd1023, 1'b1, MARK_UNDET, 1'b0, 1'b0, 11'd1024));
    plan.push_back(item_row(KIND_APPLY, 10'd0, 1'b0));
    plan.push_back(item_row(KIND_APPLY, 10'd1023, 1'b1));
    plan.push_back(item_row(KIND_READ, 10'd1023, 1'b0));
    // Zero deciders acts as one: two entries
    plan.push_back(cfg_row(4'd0));
    plan.push_back(typed_row(KIND_READ, 10'd2, 1'b0, MARK_UNDET, 1'b0, 1'b1, 11'd2));
    plan.push_back(typed_row(KIND_APPLY, 10'd1023, 1'b1, MARK_UNDET, 1'b0, 1'b1, 11'd2));
    // Empty set included fills the table and then conflicts everywhere
    plan.push_back(typed_row(KIND_APPLY, 10'd0, 1'b1, MARK_UNDET, 1'b1, 1'b0, 11'd0));
    plan.push_back(typed_row(KIND_READ, 10'd1, 1'b0, MARK_INCL, 1'b0, 1'b0, 11'd0));
    plan.push_back(typed_row(KIND_APPLY, 10'd1, 1'b0, MARK_UNDET, 1'b1, 1'b0, 11'd0));
    // Oversized register clamps to ten deciders
    plan.push_back(cfg_row(4'd15));
    plan.push_back(typed_row(KIND_READ, 10'd1023, 1'b0, MARK_UNDET, 1'b0, 1'b0, 11'd1024));
    plan.push_back(typed_row(KIND_APPLY, 10'd1023, 1'b0, MARK_UNDET, 1'b0, 1'b0, 11'd0));
    plan.push_back(typed_row(KIND_APPLY, 10'd1, 1'b1, MARK_UNDET, 1'b1, 1'b0, 11'd0));
    // Small table, mixed decisions
    plan.push_back(cfg_row(4'd3));
    plan.push_back(item_row(KIND_APPLY, 10'd5, 1'b1));
    plan.push_back(item_row(KIND_APPLY, 10'd2, 1'b0));
    plan.push_back(item_row(KIND_READ, 10'd5, 1'b1));
    plan.push_back(item_row(KIND_READ, 10'd2, 1'b0));
    plan.push_back(item_row(KIND_READ, 10'd8, 1'b0));
    plan.push_back(item_row(KIND_APPLY, 10'd7, 1'b0));
    plan.push_back(item_row(KIND_APPLY, 10'd6, 1'b1));
    plan.push_back(item_row(KIND_READ, 10'd0, 1'b0));

    send_idle_pct <= 6;
    recv_idle_pct <= 49;
    load_deciders(DECIDERS_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed rows
    foreach (plan[i]) begin
      if (plan[i].action == ROW_CFG)
        write_deciders(plan[i].cfg_value);
      else
        send_item(plan[i].kind, plan[i].subset, plan[i].present, plan[i].typed,
                  plan[i].want);
    end

    // Random phases, one table size each; swap idling from the fourth phase, then run without it from the seventh
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle_pct <= 49;
        recv_idle_pct <= 6;
      end else if (p == 6) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      write_deciders(phase_deciders[p]);
      size = 1 << n_active;
      for (int k = 0; k < phase_items[p]; k++) begin
        kind = ($urandom_range(99) < 45) ? KIND_READ : KIND_APPLY;
        if ($urandom_range(9) == 0) subset = 10'($urandom_range(1023));
        else subset = 10'($urandom_range(size - 1));
        send_item(kind, subset, 1'($urandom_range(1)), 1'b0, '0);
        if (p == 1 && k == phase_items[p] / 2) wait_for_results();
      end
    end

    wait_for_results();
    repeat (16) @(posedge clk);

    $display("covered %0d items over seven table sizes including clamped register values",
             items_sent);
    $display("results: %0d reads, %0d conflicts, %0d out of range, %0d fully determined",
             reads_seen, conflicts_seen, oor_seen, determined_seen);
    if (mismatch_count == 0)
      $display("monotone_closure_table_tb OK");
    else
      $display("monotone_closure_table_tb NOT OK");
    $finish;
  end

endmodule

// ----- monotone_closure_table.f -----
rtl/core/mct_pkg.sv
rtl/core/mct_cmd_queue.sv
rtl/core/mct_front.sv
rtl/core/mct_back.sv
rtl/core/monotone_closure_table.sv
test/monotone_closure_table_tb.sv
